/* rtl/pba_pkg.sv */
package pba_pkg;

  localparam int PAGE_COUNT = 65536;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_W     = 16;
  localparam int CNT_W      = 17;
  localparam int WIDX_W     = 11;
  localparam int BIT_W      = 5;
  localparam int CFG_W      = 12;
  localparam logic [31:0] FULL_WORD = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
    logic              stack_area;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] first_page;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic mark;
    logic free;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_alloc;
    logic req_bad;
    logic hit;
    logic scan_end;
    logic found;
    logic cnt_zero;
    logic dbl;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/pba_ctrl.sv */
module pba_ctrl import pba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MARK  = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (sts.req_alloc)    state_next = S_SCAN;
          else if (sts.req_bad) state_next = S_DONE;
          else                  state_next = S_FREE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end)                state_next = S_DONE;
        else if (sts.hit && sts.found)   state_next = S_MARK;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.cnt_zero) state_next = S_DONE;
      end
      S_FREE: begin
        cmd.free = 1'b1;
        if (sts.cnt_zero || (sts.hit && sts.dbl)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign req_stall = (state != S_IDLE);

endmodule

/* rtl/pba_dp.sv */
module pba_dp import pba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  output rsp_t             rsp,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts
);

  logic [31:0]       mem [MAP_WORDS];
  logic [31:0]       rd_q;
  logic              mem_we, mem_re;
  logic [WIDX_W-1:0] mem_wa, mem_ra;
  logic [31:0]       mem_wd;

  logic [CFG_W-1:0]  words_in_use;
  logic [WIDX_W-1:0] clr;
  logic [WIDX_W-1:0] hint;
  logic [WIDX_W-1:0] cw_idx;
  logic [31:0]       cw_data;
  logic              cw_valid, cw_dirty, pend;

  logic [1:0]        op;
  logic              down, seen;
  logic [CNT_W-1:0]  ptr, cnt, run;
  logic [PAGE_W-1:0] start, first;
  logic [1:0]        stat;

  logic [CNT_W-1:0]  lim, ptr_m1;
  logic [PAGE_W-1:0] cur, res;
  logic              hit, bit_used, found, scan_end, cnt_zero, access, dbl;
  logic [CNT_W:0]    run_inc;

  always_comb begin
    if (words_in_use >= CFG_W'(MAP_WORDS)) lim = CNT_W'(PAGE_COUNT);
    else lim = {1'b0, words_in_use[WIDX_W-1:0], {BIT_W{1'b0}}};
  end

  assign ptr_m1   = ptr - 1'b1;
  assign cur      = down ? ptr_m1[PAGE_W-1:0] : ptr[PAGE_W-1:0];
  assign hit      = cw_valid && (cw_idx == cur[PAGE_W-1:BIT_W]);
  assign bit_used = cw_data[cur[BIT_W-1:0]];
  assign run_inc  = {1'b0, run} + 1'b1;
  assign found    = !bit_used && (run_inc >= {1'b0, cnt});
  assign res      = (down || run == '0) ? cur : start;
  assign scan_end = down ? (ptr == '0) : (ptr >= lim);
  assign cnt_zero = (cnt == '0);
  assign dbl      = (op == OP_FREE) && !bit_used;
  assign access   = (cmd.scan && !scan_end) || ((cmd.mark || cmd.free) && !cnt_zero);

  always_comb begin
    sts = '0;
    sts.clear_last = (clr == WIDX_W'(MAP_WORDS - 1));
    sts.req_alloc  = (req.opcode == OP_ALLOC);
    sts.req_bad    = ({2'b0, req.page} + {1'b0, req.count}) > (CNT_W+1)'(PAGE_COUNT);
    sts.hit        = hit;
    sts.scan_end   = scan_end;
    sts.found      = found;
    sts.cnt_zero   = cnt_zero;
    sts.dbl        = dbl;
    sts.out_busy   = rsp_valid && rsp_stall;
  end

  // memory port: clearing sweep, or writeback plus read on a cache miss
  always_comb begin
    mem_re = access && !hit && !pend;
    mem_ra = cur[PAGE_W-1:BIT_W];
    mem_we = cmd.clear || (mem_re && cw_dirty);
    mem_wa = cmd.clear ? clr : cw_idx;
    mem_wd = cmd.clear ? FULL_WORD : cw_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= CFG_W'(MAP_WORDS);
      clr          <= '0;
      hint         <= '0;
      cw_valid     <= 1'b0;
      cw_dirty     <= 1'b0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid) words_in_use <= cfg_data;
      if (cmd.clear) clr <= clr + 1'b1;

      if (cmd.finish) begin
        rsp_valid      <= 1'b1;
        rsp.first_page <= first;
        rsp.status     <= stat;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cmd.load) begin
        op    <= req.opcode;
        down  <= (req.opcode == OP_ALLOC) && req.stack_area;
        cnt   <= req.count;
        run   <= '0;
        seen  <= 1'b0;
        if (req.opcode == OP_ALLOC) begin
          first <= '0;
          stat  <= ST_OK;
          ptr   <= req.stack_area ? lim : {1'b0, hint, {BIT_W{1'b0}}};
        end else begin
          first <= req.page;
          stat  <= sts.req_bad ? ST_RANGE : ST_OK;
          ptr   <= {1'b0, req.page};
        end
      end

      if (cmd.scan && scan_end) begin
        first <= '0;
        stat  <= ST_NOSPACE;
      end

      if (access && !hit) begin
        if (!pend) begin
          pend     <= 1'b1;
          cw_dirty <= 1'b0;
        end else begin
          pend     <= 1'b0;
          cw_data  <= rd_q;
          cw_idx   <= cur[PAGE_W-1:BIT_W];
          cw_valid <= 1'b1;
        end
      end

      if (access && hit) begin
        if (cmd.scan) begin
          if (bit_used) begin
            run <= '0;
            ptr <= down ? ptr_m1 : ptr + 1'b1;
          end else begin
            if (!down && !seen) begin
              hint <= cur[PAGE_W-1:BIT_W];
              seen <= 1'b1;
            end
            if (run == '0) start <= cur;
            run <= run_inc[CNT_W-1:0];
            if (found) begin
              first <= res;
              ptr   <= {1'b0, res};
              down  <= 1'b0;
            end else begin
              ptr <= down ? ptr_m1 : ptr + 1'b1;
            end
          end
        end
        if (cmd.mark) begin
          cw_data[cur[BIT_W-1:0]] <= 1'b1;
          cw_dirty <= 1'b1;
          ptr <= ptr + 1'b1;
          cnt <= cnt - 1'b1;
        end
        if (cmd.free) begin
          if (dbl) begin
            first <= cur;
            stat  <= ST_DOUBLE;
          end else begin
            cw_data[cur[BIT_W-1:0]] <= (op == OP_RESERVE);
            cw_dirty <= 1'b1;
            if (op != OP_RESERVE && cur[PAGE_W-1:BIT_W] < hint) hint <= cur[PAGE_W-1:BIT_W];
            ptr <= ptr + 1'b1;
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/page_bitmap_allocator_core.sv */
// Page bitmap allocator: one used bit per page, 2048 map words of 32 bits.
// Request channel (req_valid/req_stall/req) takes one beat per operation:
// alloc, checked free, unchecked release or reserve. Response channel
// (rsp_valid/rsp_stall/rsp) returns exactly one beat per request with the
// first page and a status code.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes words_in_use; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. The block handles one request at a time.
// Entering a new map word takes a RAM read, with the cached word written
// back in the same cycle if dirty, then the refill. A free, release or
// reserve that runs past the map end answers without touching the map,
// with the range status.
// After reset a clearing pass over all 2048 map words fills the map with ones
// (all pages used); req_stall stays high during it.
// A finished response sits in an output register; the next request is taken
// while it waits. A stalled response holds the block before it writes the
// following response.
module page_bitmap_allocator_core import pba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
